// ===== design/wlh_pkg.sv =====
package wlh_pkg;

    localparam int LenOutW = 6;
    localparam int CntOutW = 32;

    localparam logic [7:0] SpaceByte = 8'h20;

    // report sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FLUSH = 4'b0010,
        S_READ  = 4'b0100,
        S_SHOW  = 4'b1000
    } t_state;

    // requests from the control side to the bin store
    typedef struct packed {
        logic inc;  // read the bin at the address, write it back plus one
        logic rd;   // plain read for the report
        logic clr;  // drop every bin back to zero
    } t_bin_ctrl;

    // Word separators: ASCII punctuation and whitespace, plus every byte
    // that occurs in the UTF-8 forms of the curly quotes and long dashes.
    function automatic logic is_delim(input logic [7:0] b);
        logic d;
        case (b)
            8'h20, 8'h2E, 8'h2C, 8'h3B, 8'h0A, 8'h09,
            8'h3F, 8'h21, 8'h2A, 8'h3A, 8'h2D, 8'h2F,
            8'h22, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B,
            8'h7D, 8'h3C, 8'h3E, 8'h5F,
            8'hE2, 8'h80, 8'h92, 8'h93, 8'h94,
            8'h98, 8'h99, 8'h9C, 8'h9D: d = 1'b1;
            default:                    d = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/wlh_if.sv =====
interface wlh_in_if
    import wlh_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] text_byte;

    modport source (output valid, output command, output text_byte, input ready);
    modport sink   (input valid, input command, input text_byte, output ready);
endinterface

interface wlh_out_if
    import wlh_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LenOutW-1:0] bin_length;
    logic [CntOutW-1:0] bin_count;
    logic [CntOutW-1:0] word_total;
    logic [CntOutW-1:0] nonspace_total;
    logic [CntOutW-1:0] all_char_total;
    logic [LenOutW-1:0] longest;
    logic               last_of_run;

    modport source (
        output valid, output bin_length, output bin_count, output word_total,
        output nonspace_total, output all_char_total, output longest,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input bin_length, input bin_count, input word_total,
        input nonspace_total, input all_char_total, input longest,
        input last_of_run, output ready
    );
endinterface

// ===== design/wlh_bin_store.sv =====
module wlh_bin_store
    import wlh_pkg::*;
#(
    parameter int BINS        = 64,
    parameter int COUNT_WIDTH = 32,
    localparam int AW         = $clog2(BINS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_bin_ctrl              i_ctrl,
    input  logic [AW-1:0]          i_addr,
    output logic [COUNT_WIDTH-1:0] o_rd_data
);

    logic [COUNT_WIDTH-1:0] r_mem [BINS];
    logic [BINS-1:0]        r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic                   r_wb_pend;
    logic [AW-1:0]          r_wb_addr;

    logic [COUNT_WIDTH-1:0] w_cur;
    logic [COUNT_WIDTH-1:0] w_inc;

    // an entry never written since the last clear reads as zero
    assign w_cur     = r_rd_vld ? r_rd_data : '0;
    assign w_inc     = (&w_cur) ? w_cur : w_cur + 1'b1;
    assign o_rd_data = w_cur;

    // Two closes of the same length have a whole word between them, so the
    // writeback always lands before the next read of that entry.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.inc || i_ctrl.rd) begin
            r_rd_data <= r_mem[i_addr];
        end
        if (r_wb_pend) begin
            r_mem[r_wb_addr] <= w_inc;
        end
        r_wb_addr <= i_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_vld  <= 1'b0;
            r_wb_pend <= 1'b0;
        end else begin
            r_wb_pend <= i_ctrl.inc;
            if (i_ctrl.inc || i_ctrl.rd) begin
                r_rd_vld <= r_valid[i_addr];
            end
            if (i_ctrl.clr) begin
                r_valid <= '0;
            end else if (r_wb_pend) begin
                r_valid[r_wb_addr] <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_clr_during_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_pend |-> !i_ctrl.clr)
        else $error("bin clear while writeback pending");

    a_wb_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wb_pend && !i_ctrl.clr) |=> r_valid[$past(r_wb_addr)])
        else $error("written bin not marked valid");

    a_no_back_to_back_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_pend |-> !(i_ctrl.inc && i_addr == r_wb_addr))
        else $error("same bin incremented on consecutive cycles");
`endif

endmodule

// ===== design/word_length_histogram.sv =====
// Word length histogram over a byte stream.
//
// Input channel i_in: one beat per text byte (command 0) or one end-of-text
// beat (command 1). Text bytes are taken one per cycle; ready is high
// whenever no report is running. Each closed word shorter than BINS is
// binned by a read-modify-write of the bin memory, written back next cycle.
//
// End of text: the open word is closed, then FLUSH and READ lead into the
// report. One result beat leaves o_out per word length from 1 to the longest
// binned length (a single beat with length 0 if no word was binned), each
// result taking one bin memory read and one output state. The last beat
// carries last_of_run; when it is taken the counters, the longest length and
// all bins are cleared and the next text is accepted the cycle after.
//
// A stalled receiver simply holds the current result; no input is taken
// until the report ends. Reset clears every counter and marks all bins empty
// at once, so the block accepts text in the first cycle after reset.
module word_length_histogram
    import wlh_pkg::*;
#(
    parameter int BINS        = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wlh_in_if.sink    i_in,
    wlh_out_if.source o_out
);

    localparam int AW   = $clog2(BINS);
    localparam int CLW  = $clog2(BINS + 1);
    localparam int LenW = (AW > LenOutW) ? AW : LenOutW;
    localparam int MaxW = (COUNT_WIDTH > CntOutW) ? COUNT_WIDTH : CntOutW;

    t_state                 r_state,    n_state;
    logic [CLW-1:0]         r_cur_len,  n_cur_len;
    logic [COUNT_WIDTH-1:0] r_words,    n_words;
    logic [COUNT_WIDTH-1:0] r_nonspace, n_nonspace;
    logic [COUNT_WIDTH-1:0] r_spaces,   n_spaces;
    logic [AW-1:0]          r_longest,  n_longest;
    logic [AW-1:0]          r_k,        n_k;

    t_bin_ctrl              w_bin_ctrl;
    logic [AW-1:0]          w_bin_addr;
    logic [COUNT_WIDTH-1:0] w_bin_data;

    logic                   w_in_acc;
    logic                   w_last;
    logic [COUNT_WIDTH-1:0] w_words_inc;
    logic [COUNT_WIDTH-1:0] w_nonspace_inc;
    logic [COUNT_WIDTH-1:0] w_spaces_inc;
    logic [COUNT_WIDTH:0]   w_sum;
    logic [COUNT_WIDTH-1:0] w_all;
    logic [MaxW-1:0]        w_bin_ext;
    logic [MaxW-1:0]        w_words_ext;
    logic [MaxW-1:0]        w_nonspace_ext;
    logic [MaxW-1:0]        w_all_ext;
    logic [LenW-1:0]        w_len_ext;
    logic [LenW-1:0]        w_longest_ext;

    wlh_bin_store #(
        .BINS        (BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bins (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_bin_ctrl),
        .i_addr    (w_bin_addr),
        .o_rd_data (w_bin_data)
    );

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_last   = (r_longest == '0) || (r_k == r_longest);

    assign w_words_inc    = (&r_words)    ? r_words    : r_words + 1'b1;
    assign w_nonspace_inc = (&r_nonspace) ? r_nonspace : r_nonspace + 1'b1;
    assign w_spaces_inc   = (&r_spaces)   ? r_spaces   : r_spaces + 1'b1;

    assign w_sum = {1'b0, r_nonspace} + {1'b0, r_spaces};
    assign w_all = w_sum[COUNT_WIDTH] ? '1 : w_sum[COUNT_WIDTH-1:0];

    always_comb begin
        n_state    = r_state;
        n_cur_len  = r_cur_len;
        n_words    = r_words;
        n_nonspace = r_nonspace;
        n_spaces   = r_spaces;
        n_longest  = r_longest;
        n_k        = r_k;
        w_bin_ctrl = '0;
        w_bin_addr = r_k;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!i_in.command) begin
                        if (i_in.text_byte == SpaceByte) begin
                            n_spaces = w_spaces_inc;
                        end else begin
                            n_nonspace = w_nonspace_inc;
                        end
                    end
                    if (i_in.command || is_delim(i_in.text_byte)) begin
                        if (r_cur_len != '0) begin
                            n_words = w_words_inc;
                            // overlong words are counted but not binned
                            if (r_cur_len < CLW'(BINS)) begin
                                w_bin_ctrl.inc = 1'b1;
                                w_bin_addr     = r_cur_len[AW-1:0];
                                if (r_cur_len[AW-1:0] > r_longest) begin
                                    n_longest = r_cur_len[AW-1:0];
                                end
                            end
                        end
                        n_cur_len = '0;
                    end else if (r_cur_len < CLW'(BINS)) begin
                        n_cur_len = r_cur_len + 1'b1;
                    end
                    if (i_in.command) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                // bin 0 is never written, so it reads zero for the empty report
                n_k     = (r_longest == '0) ? '0 : AW'(1);
                n_state = S_READ;
            end
            S_READ: begin
                w_bin_ctrl.rd = 1'b1;
                n_state       = S_SHOW;
            end
            S_SHOW: begin
                if (o_out.ready) begin
                    if (w_last) begin
                        n_words        = '0;
                        n_nonspace     = '0;
                        n_spaces       = '0;
                        n_longest      = '0;
                        n_cur_len      = '0;
                        w_bin_ctrl.clr = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_len  <= '0;
            r_words    <= '0;
            r_nonspace <= '0;
            r_spaces   <= '0;
            r_longest  <= '0;
        end else begin
            r_state    <= n_state;
            r_cur_len  <= n_cur_len;
            r_words    <= n_words;
            r_nonspace <= n_nonspace;
            r_spaces   <= n_spaces;
            r_longest  <= n_longest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
    end

    // outputs show the low bits of the wider internal values
    assign w_bin_ext      = MaxW'(w_bin_data);
    assign w_words_ext    = MaxW'(r_words);
    assign w_nonspace_ext = MaxW'(r_nonspace);
    assign w_all_ext      = MaxW'(w_all);
    assign w_len_ext      = LenW'(r_k);
    assign w_longest_ext  = LenW'(r_longest);

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_SHOW);
    assign o_out.bin_length     = w_len_ext[LenOutW-1:0];
    assign o_out.bin_count      = w_bin_ext[CntOutW-1:0];
    assign o_out.word_total     = w_words_ext[CntOutW-1:0];
    assign o_out.nonspace_total = w_nonspace_ext[CntOutW-1:0];
    assign o_out.all_char_total = w_all_ext[CntOutW-1:0];
    assign o_out.longest        = w_longest_ext[LenOutW-1:0];
    assign o_out.last_of_run    = w_last;

`ifndef SYNTHESIS
    a_no_input_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input taken while a report runs");

    a_end_starts_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.command) |=> (r_state == S_FLUSH && r_cur_len == '0))
        else $error("end of text did not close the word and start the report");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_of_run) |=>
            (r_words == '0 && r_longest == '0 && r_nonspace == '0 && r_spaces == '0))
        else $error("state not cleared after report");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_len <= CLW'(BINS))
        else $error("word length counter past saturation");

    a_k_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_k <= r_longest))
        else $error("report length beyond longest");
`endif

endmodule

// ===== bench/tb_word_length_histogram.sv =====
module tb_word_length_histogram;
    import wlh_pkg::*;

    localparam int BINS         = 64;
    localparam int NUM_ROWS     = 24;
    localparam int RANDOM_BEATS = 186;
    localparam int QUIET_AFTER  = NUM_ROWS + 170;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum int {
        TEXT_PROSE,
        TEXT_NOISE,
        TEXT_LONG
    } t_text_kind;

    typedef struct packed {
        logic [LenOutW-1:0] bin_length;
        logic [CntOutW-1:0] bin_count;
        logic [CntOutW-1:0] word_total;
        logic [CntOutW-1:0] nonspace_total;
        logic [CntOutW-1:0] all_char_total;
        logic [LenOutW-1:0] longest;
        logic               last_of_run;
    } t_bin_report;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  text_byte;
        logic        typed;
        t_bin_report want;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    wlh_in_if  in_beat_if ();
    wlh_out_if out_beat_if ();

    word_length_histogram u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_beat_if),
        .o_out   (out_beat_if)
    );

    always #5 i_clk = ~i_clk;

    // word separators, including every byte of the UTF-8 quotes and dashes
    logic [7:0] sep_bytes [0:30] = '{
        8'h20, 8'h2E, 8'h2C, 8'h3B, 8'h0A, 8'h09, 8'h3F, 8'h21,
        8'h2A, 8'h3A, 8'h2D, 8'h2F, 8'h22, 8'h28, 8'h29, 8'h5B,
        8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h5F, 8'hE2, 8'h80,
        8'h92, 8'h93, 8'h94, 8'h98, 8'h99, 8'h9C, 8'h9D
    };

    t_stim_row   directed_rows [NUM_ROWS];
    t_bin_report expected_reports [$];

    // histogram shadow state
    logic [6:0]         open_len;
    logic [CntOutW-1:0] word_cnt;
    logic [CntOutW-1:0] nonspace_cnt;
    logic [CntOutW-1:0] space_cnt;
    logic [5:0]         longest_len;
    logic [CntOutW-1:0] len_bins [BINS];

    int error_count = 0;
    int beats_sent  = 0;
    int cycle_count = 0;
    bit no_idle     = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;

    function automatic logic is_sep(input logic [7:0] b);
        foreach (sep_bytes[i])
            if (sep_bytes[i] == b) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [CntOutW-1:0] sat_inc(input logic [CntOutW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [CntOutW-1:0] sat_add(input logic [CntOutW-1:0] a,
                                                   input logic [CntOutW-1:0] b);
        logic [CntOutW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CntOutW] ? '1 : s[CntOutW-1:0];
    endfunction

    function automatic void clear_histogram();
        open_len     = '0;
        word_cnt     = '0;
        nonspace_cnt = '0;
        space_cnt    = '0;
        longest_len  = '0;
        foreach (len_bins[i]) len_bins[i] = '0;
    endfunction

    function automatic void close_open_word();
        if (open_len == 0) return;
        word_cnt = sat_inc(word_cnt);
        if (open_len < BINS) begin
            len_bins[open_len[5:0]] = sat_inc(len_bins[open_len[5:0]]);
            if (open_len[5:0] > longest_len) longest_len = open_len[5:0];
        end
        open_len = '0;
    endfunction

    function automatic t_bin_report mk_report(input int len, input int cnt, input int words,
                                              input int nons, input int all, input int lng,
                                              input int last);
        t_bin_report r;
        r.bin_length     = len[LenOutW-1:0];
        r.bin_count      = cnt;
        r.word_total     = words;
        r.nonspace_total = nons;
        r.all_char_total = all;
        r.longest        = lng[LenOutW-1:0];
        r.last_of_run    = last[0];
        return r;
    endfunction

    // Updates the shadow histogram with one accepted beat and queues the
    // report beats that an end of text produces. A typed row replaces the
    // computed report with its own single entry.
    function automatic void advance_histogram(input logic cmd, input logic [7:0] b,
                                              input logic typed, input t_bin_report want);
        logic [CntOutW-1:0] all;
        int                 n;
        t_bin_report        r;
        if (cmd == CMD_TEXT) begin
            if (b == SpaceByte) space_cnt = sat_inc(space_cnt);
            else                nonspace_cnt = sat_inc(nonspace_cnt);
            if (is_sep(b))            close_open_word();
            else if (open_len < BINS) open_len = open_len + 1'b1;
            return;
        end
        close_open_word();
        all = sat_add(nonspace_cnt, space_cnt);
        n = (longest_len == 0) ? 1 : int'(longest_len);
        if (typed) begin
            expected_reports.push_back(want);
        end else begin
            for (int k = 0; k < n; k++) begin
                r.bin_length     = (longest_len == 0) ? '0 : LenOutW'(k + 1);
                r.bin_count      = (longest_len == 0) ? '0 : len_bins[k + 1];
                r.word_total     = word_cnt;
                r.nonspace_total = nonspace_cnt;
                r.all_char_total = all;
                r.longest        = longest_len;
                r.last_of_run    = (k + 1 == n);
                expected_reports.push_back(r);
            end
        end
        clear_histogram();
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Called at a falling edge; returns at the falling edge after the beat
    // was taken, with valid still high.
    task automatic drive_beat(input logic cmd, input logic [7:0] b,
                              input logic typed, input t_bin_report want);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            in_beat_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_beat_if.valid     <= 1'b1;
        in_beat_if.command   <= cmd;
        in_beat_if.text_byte <= b;
        do @(posedge i_clk); while (!in_beat_if.ready);
        advance_histogram(cmd, b, typed, want);
        beats_sent++;
        if (beats_sent >= QUIET_AFTER) no_idle = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_beat_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_word(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            do b = 8'($urandom_range(0, 255)); while (is_sep(b));
            drive_beat(CMD_TEXT, b, 1'b0, '0);
        end
    endtask

    task automatic send_gap();
        repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 1) == 0)
                drive_beat(CMD_TEXT, SpaceByte, 1'b0, '0);
            else
                drive_beat(CMD_TEXT, sep_bytes[$urandom_range(0, 30)], 1'b0, '0);
        end
    endtask

    task automatic send_text(input t_text_kind kind);
        int nw;
        int len;
        case (kind)
            TEXT_PROSE: begin
                if ($urandom_range(0, 2) == 0) send_gap();
                nw = $urandom_range(1, 5);
                for (int w = 0; w < nw; w++) begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 8);
                    send_word(len);
                    if (w < nw - 1 || $urandom_range(0, 1) == 0) send_gap();
                end
            end
            TEXT_NOISE: begin
                repeat ($urandom_range(4, 16))
                    drive_beat(($urandom_range(0, 7) == 0) ? CMD_END : CMD_TEXT,
                               8'($urandom_range(0, 255)), 1'b0, '0);
            end
            TEXT_LONG: begin
                send_word($urandom_range(1, 4));
                send_gap();
                // longest binnable word, then one too long to bin
                send_word(BINS - 1);
                send_gap();
                send_word($urandom_range(BINS, BINS + 6));
                if ($urandom_range(0, 1) == 0) send_gap();
            end
            default: ;
        endcase
        drive_beat(CMD_END, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // result receiver: random back-pressure plus one long hold-off
    initial begin : result_sink
        int hold_cycles;
        out_beat_if.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                out_beat_if.ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    hold_cycles++;
                end
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                out_beat_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end else begin
                out_beat_if.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_bin_report want;
        if (i_rst_n && out_beat_if.valid && out_beat_if.ready) begin
            if (expected_reports.size() == 0) begin
                flag_error("result beat with nothing pending");
            end else begin
                want = expected_reports.pop_front();
                check_field("bin_length", 32'(out_beat_if.bin_length),
                            32'(want.bin_length));
                check_field("bin_count", out_beat_if.bin_count, want.bin_count);
                check_field("word_total", out_beat_if.word_total, want.word_total);
                check_field("nonspace_total", out_beat_if.nonspace_total,
                            want.nonspace_total);
                check_field("all_char_total", out_beat_if.all_char_total,
                            want.all_char_total);
                check_field("longest", 32'(out_beat_if.longest), 32'(want.longest));
                check_field("last_of_run", 32'(out_beat_if.last_of_run),
                            32'(want.last_of_run));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("word_length_histogram regression: fail");
        $finish;
    end

    initial begin : stimulus
        int t;
        in_beat_if.valid     = 1'b0;
        in_beat_if.command   = CMD_TEXT;
        in_beat_if.text_byte = '0;
        clear_histogram();

        directed_rows = '{
            // end of text straight after reset: one empty entry
            '{CMD_END,  8'h00, 1'b1, mk_report(0, 0, 0, 0, 0, 0, 1)},
            '{CMD_TEXT, 8'h20, 1'b0, '0},
            // byte field ignored on end of text; a lone space is no word
            '{CMD_END,  8'hFF, 1'b1, mk_report(0, 0, 0, 0, 1, 0, 1)},
            '{CMD_TEXT, 8'h61, 1'b0, '0},
            // open word closed by end of text
            '{CMD_END,  8'h00, 1'b1, mk_report(1, 1, 1, 1, 1, 1, 1)},
            '{CMD_TEXT, 8'h00, 1'b0, '0},
            '{CMD_TEXT, 8'hFF, 1'b0, '0},
            '{CMD_TEXT, 8'hE2, 1'b0, '0},
            '{CMD_TEXT, 8'h80, 1'b0, '0},
            '{CMD_TEXT, 8'h94, 1'b0, '0},
            '{CMD_TEXT, 8'h7F, 1'b0, '0},
            '{CMD_TEXT, 8'h0A, 1'b0, '0},
            '{CMD_TEXT, 8'h41, 1'b0, '0},
            '{CMD_TEXT, 8'h42, 1'b0, '0},
            '{CMD_TEXT, 8'h43, 1'b0, '0},
            '{CMD_TEXT, 8'h09, 1'b0, '0},
            '{CMD_TEXT, 8'h9D, 1'b0, '0},
            '{CMD_TEXT, 8'h5F, 1'b0, '0},
            '{CMD_TEXT, 8'h21, 1'b0, '0},
            '{CMD_TEXT, 8'h7E, 1'b0, '0},
            '{CMD_END,  8'h00, 1'b0, '0},
            '{CMD_TEXT, 8'h2E, 1'b0, '0},
            '{CMD_TEXT, 8'h2E, 1'b0, '0},
            // delimiters only: no words, nonspace bytes still counted
            '{CMD_END,  8'h5A, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            drive_beat(directed_rows[i].cmd, directed_rows[i].text_byte,
                       directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // results held back from the first report on while text keeps coming
        hold_req = 1'b1;
        t = 0;
        while (beats_sent < NUM_ROWS + RANDOM_BEATS) begin
            if (t == 1)          send_text(TEXT_LONG);
            else if (t % 4 == 2) send_text(TEXT_NOISE);
            else                 send_text(TEXT_PROSE);
            if (t == 2) wait_drained();
            t++;
        end
        in_beat_if.valid <= 1'b0;

        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_reports.size()));

        if (error_count == 0)
            $display("word_length_histogram regression: pass");
        else
            $display("word_length_histogram regression: fail");
        $finish;
    end

endmodule

// ===== word_length_histogram.f =====
design/wlh_pkg.sv
design/wlh_if.sv
design/wlh_bin_store.sv
design/word_length_histogram.sv
bench/tb_word_length_histogram.sv
